// File: hw/rtl/jpeg_header_marker_parser_unit_defines.svh
// Assertion macros shared by the marker parser checkers.
`ifndef JPEG_HEADER_MARKER_PARSER_UNIT_DEFINES_SVH
`define JPEG_HEADER_MARKER_PARSER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define JHMP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define JHMP_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/jhmp_pkg.sv
// Types, record codes and constant tables of the marker parser.
package jhmp_pkg;

   localparam int OUT_DEPTH = 4;

   // Record kinds.
   localparam logic [3:0] KIND_SCAN   = 4'd0;
   localparam logic [3:0] KIND_HEIGHT = 4'd1;
   localparam logic [3:0] KIND_WIDTH  = 4'd2;
   localparam logic [3:0] KIND_FCOMP  = 4'd3;
   localparam logic [3:0] KIND_SCOMP  = 4'd4;
   localparam logic [3:0] KIND_QUANT  = 4'd5;
   localparam logic [3:0] KIND_HUFF   = 4'd6;
   localparam logic [3:0] KIND_DONE   = 4'd7;
   localparam logic [3:0] KIND_ERROR  = 4'd8;

   // Error codes.
   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_JFIF      = 3'd1;
   localparam logic [2:0] ERR_COMP_CNT  = 3'd2;
   localparam logic [2:0] ERR_QUANT_ID  = 3'd3;
   localparam logic [2:0] ERR_EOF_SCAN  = 3'd4;

   // Marker bytes.
   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] BYTE_00  = 8'h00;
   localparam logic [7:0] MRK_DQT  = 8'hDB;
   localparam logic [7:0] MRK_SOF0 = 8'hC0;
   localparam logic [7:0] MRK_DHT  = 8'hC4;
   localparam logic [7:0] MRK_SOS  = 8'hDA;
   localparam logic [7:0] MRK_EOI  = 8'hD9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       at_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_kind;
      logic [15:0] out_value;
      logic [1:0]  table_sel;
      logic [7:0]  comp_id;
      logic [3:0]  samp_x;
      logic [3:0]  samp_y;
      logic [7:0]  quant_sel;
      logic [3:0]  dc_table;
      logic [4:0]  ac_table;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // SOI followed by the APP0 marker.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'hFF;
         2'd1:    b = 8'hD8;
         2'd2:    b = 8'hFF;
         default: b = 8'hE0;
      endcase
      return b;
   endfunction

   // "JFIF" and its terminating zero.
   function automatic logic [7:0] jfif_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h4A;
         3'd1:    b = 8'h46;
         3'd2:    b = 8'h49;
         3'd3:    b = 8'h46;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/jpeg_header_marker_parser_unit.sv
// JPEG baseline marker parser: one file byte in, up to two records out.
//
//   Channel  Direction  Payload    Transfer
//   req_     in         req_type   req_valid & req_ready
//   rsp_     out        rsp_type   rsp_valid & rsp_ready
//
// One byte is taken per cycle while req_ready is high; its records are written
// straight into an OutDepth-entry output queue and are registered there before rsp_.
// req_ready is high while the queue has room for two records, so the rate
// is one byte per cycle as long as the sink takes one record per cycle.
// A scan byte that follows a lone FF makes two records, but the FF made none,
// so the pair still needs one sink cycle per byte. Reset empties the queue.
// After done or an error the parser keeps taking bytes and produces nothing.
module jpeg_header_marker_parser_unit
   import jhmp_pkg::*;
#(
   parameter int OutDepth = OUT_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
   localparam int CntW = $clog2(OutDepth + 1);

   typedef enum logic [4:0] {
      PH_MAGIC, PH_APPLEN, PH_JFIF, PH_HUNT, PH_MARK,
      PH_DQT_LEN, PH_DQT_ID, PH_DQT_DATA,
      PH_SOF_SKIP, PH_SOF_H, PH_SOF_W, PH_SOF_N, PH_SOF_COMP,
      PH_DHT_LEN, PH_DHT_ID, PH_DHT_DATA,
      PH_SOS_SKIP, PH_SOS_N, PH_SOS_COMP, PH_SOS_TAIL,
      PH_SCAN, PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  hold_ff, hold_in;
   logic [1:0]  total_ff, total_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  cid_ff, cid_in;
   logic [7:0]  samp_ff, samp_in;
   logic [1:0]  table_ff, table_in;
   logic        pending_ff, pending_in;

   rsp_type     mem_ff [OutDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_nx, wr_ptr_in, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic        req_fire, rsp_fire;
   logic [7:0]  b;
   logic [1:0]  n_push;
   rsp_type     rec0, rec1;
   logic [15:0] seg_len;
   logic [1:0]  index_inc;

   function automatic rsp_type mk_rec(input logic [3:0] kind, input logic [15:0] value);
      rsp_type r;
      r = '0;
      r.out_kind = kind;
      r.out_value = value;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] q;
      q = (p == PtrW'(OutDepth - 1)) ? '0 : p + 1'b1;
      return q;
   endfunction

   assign req_ready = (count_ff <= CntW'(OutDepth - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign b         = req_data.data_byte;
   assign seg_len   = {hold_ff, b};
   assign index_inc = index_ff + 2'd1;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      remain_in  = remain_ff;
      hold_in    = hold_ff;
      total_in   = total_ff;
      index_in   = index_ff;
      cid_in     = cid_ff;
      samp_in    = samp_ff;
      table_in   = table_ff;
      pending_in = pending_ff;
      n_push     = 2'd0;
      rec0       = mk_rec(KIND_SCAN, 16'd0);
      rec1       = mk_rec(KIND_SCAN, 16'd0);

      if (!req_fire || phase_ff == PH_HALT) begin
         // nothing to do
      end else if (req_data.at_end) begin
         phase_in = PH_HALT;
         n_push   = 2'd1;
         priority case (phase_ff)
            PH_MAGIC: begin
               rec0 = mk_rec(KIND_ERROR, 16'd0);
               rec0.error_code = ERR_MAGIC;
            end
            PH_APPLEN, PH_JFIF: begin
               rec0 = mk_rec(KIND_ERROR, 16'd0);
               rec0.error_code = ERR_JFIF;
            end
            PH_SCAN: begin
               rec0 = mk_rec(KIND_ERROR, 16'd0);
               rec0.error_code = ERR_EOF_SCAN;
            end
            default: rec0 = mk_rec(KIND_DONE, 16'd0);
         endcase
      end else begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (b != magic_byte(pos_ff[1:0])) begin
                  rec0 = mk_rec(KIND_ERROR, 16'd0);
                  rec0.error_code = ERR_MAGIC;
                  n_push   = 2'd1;
                  phase_in = PH_HALT;
               end else if (pos_ff == 3'd3) begin
                  pos_in   = '0;
                  phase_in = PH_APPLEN;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_APPLEN: begin
               if (pos_ff == 3'd1) begin
                  pos_in   = '0;
                  phase_in = PH_JFIF;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_JFIF: begin
               if (pos_ff >= 3'd5 || b != jfif_byte(pos_ff)) begin
                  rec0 = mk_rec(KIND_ERROR, 16'd0);
                  rec0.error_code = ERR_JFIF;
                  n_push   = 2'd1;
                  phase_in = PH_HALT;
               end else if (pos_ff == 3'd4) begin
                  pos_in   = '0;
                  phase_in = PH_HUNT;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_HUNT: begin
               if (b == BYTE_FF) phase_in = PH_MARK;
            end
            PH_MARK: begin
               pos_in = '0;
               priority if (b == BYTE_FF) phase_in = PH_MARK;
               else if (b == MRK_DQT)  phase_in = PH_DQT_LEN;
               else if (b == MRK_SOF0) phase_in = PH_SOF_SKIP;
               else if (b == MRK_DHT)  phase_in = PH_DHT_LEN;
               else if (b == MRK_SOS)  phase_in = PH_SOS_SKIP;
               else if (b == MRK_EOI) begin
                  rec0     = mk_rec(KIND_DONE, 16'd0);
                  n_push   = 2'd1;
                  phase_in = PH_HALT;
               end else phase_in = PH_HUNT;
            end
            PH_DQT_LEN, PH_DHT_LEN: begin
               if (pos_ff == 3'd0) begin
                  hold_in = b;
                  pos_in  = 3'd1;
               end else begin
                  // The length counts itself and the id byte.
                  remain_in = (seg_len >= 16'd3) ? seg_len - 16'd3 : 16'd0;
                  pos_in    = '0;
                  phase_in  = (phase_ff == PH_DQT_LEN) ? PH_DQT_ID : PH_DHT_ID;
               end
            end
            PH_DQT_ID: begin
               if (b > 8'd1) begin
                  rec0 = mk_rec(KIND_ERROR, 16'd0);
                  rec0.error_code = ERR_QUANT_ID;
                  n_push   = 2'd1;
                  phase_in = PH_HALT;
               end else begin
                  table_in = b[1:0];
                  phase_in = (remain_ff != 16'd0) ? PH_DQT_DATA : PH_HUNT;
               end
            end
            PH_DHT_ID: begin
               table_in = {b[7:4] != 4'd0, b[3:0] != 4'd0};
               phase_in = (remain_ff != 16'd0) ? PH_DHT_DATA : PH_HUNT;
            end
            PH_DQT_DATA, PH_DHT_DATA: begin
               rec0 = mk_rec((phase_ff == PH_DQT_DATA) ? KIND_QUANT : KIND_HUFF,
                             {8'd0, b});
               rec0.table_sel = table_ff;
               n_push    = 2'd1;
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) phase_in = PH_HUNT;
            end
            PH_SOF_SKIP: begin
               if (pos_ff == 3'd2) begin
                  pos_in   = '0;
                  phase_in = PH_SOF_H;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_SOF_H, PH_SOF_W: begin
               if (pos_ff == 3'd0) begin
                  hold_in = b;
                  pos_in  = 3'd1;
               end else begin
                  rec0 = mk_rec((phase_ff == PH_SOF_H) ? KIND_HEIGHT : KIND_WIDTH,
                                seg_len);
                  n_push   = 2'd1;
                  pos_in   = '0;
                  phase_in = (phase_ff == PH_SOF_H) ? PH_SOF_W : PH_SOF_N;
               end
            end
            PH_SOF_N, PH_SOS_N: begin
               if (b != 8'd1 && b != 8'd3) begin
                  rec0 = mk_rec(KIND_ERROR, 16'd0);
                  rec0.error_code = ERR_COMP_CNT;
                  n_push   = 2'd1;
                  phase_in = PH_HALT;
               end else begin
                  total_in = b[1:0];
                  index_in = '0;
                  pos_in   = '0;
                  phase_in = (phase_ff == PH_SOF_N) ? PH_SOF_COMP : PH_SOS_COMP;
               end
            end
            PH_SOF_COMP: begin
               if (pos_ff == 3'd0) begin
                  cid_in = b;
                  pos_in = 3'd1;
               end else if (pos_ff == 3'd1) begin
                  samp_in = b;
                  pos_in  = 3'd2;
               end else begin
                  rec0 = mk_rec(KIND_FCOMP, 16'd0);
                  rec0.comp_id   = cid_ff;
                  rec0.samp_x    = samp_ff[7:4];
                  rec0.samp_y    = samp_ff[3:0];
                  rec0.quant_sel = b;
                  n_push   = 2'd1;
                  pos_in   = '0;
                  index_in = index_inc;
                  if (index_inc >= total_ff) phase_in = PH_HUNT;
               end
            end
            PH_SOS_SKIP: begin
               if (pos_ff == 3'd1) begin
                  pos_in   = '0;
                  phase_in = PH_SOS_N;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_SOS_COMP: begin
               if (pos_ff == 3'd0) begin
                  cid_in = b;
                  pos_in = 3'd1;
               end else begin
                  rec0 = mk_rec(KIND_SCOMP, 16'd0);
                  rec0.comp_id  = cid_ff;
                  rec0.dc_table = b[7:4];
                  rec0.ac_table = {1'b0, b[3:0]} + 5'd2;
                  n_push   = 2'd1;
                  pos_in   = '0;
                  index_in = index_inc;
                  if (index_inc >= total_ff) phase_in = PH_SOS_TAIL;
               end
            end
            PH_SOS_TAIL: begin
               if (pos_ff == 3'd2) begin
                  pos_in     = '0;
                  pending_in = 1'b0;
                  phase_in   = PH_SCAN;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_SCAN: begin
               if (!pending_ff) begin
                  if (b == BYTE_FF) begin
                     pending_in = 1'b1;
                  end else begin
                     rec0   = mk_rec(KIND_SCAN, {8'd0, b});
                     n_push = 2'd1;
                  end
               end else begin
                  pending_in = 1'b0;
                  priority if (b == BYTE_00) begin
                     rec0   = mk_rec(KIND_SCAN, {8'd0, BYTE_FF});
                     n_push = 2'd1;
                  end else if (b == MRK_EOI) begin
                     rec0     = mk_rec(KIND_DONE, 16'd0);
                     n_push   = 2'd1;
                     phase_in = PH_HALT;
                  end else begin
                     // Not a stuffed byte or EOI: both bytes are scan data.
                     rec0      = mk_rec(KIND_SCAN, {8'd0, BYTE_FF});
                     rec0.last = 1'b0;
                     rec1      = mk_rec(KIND_SCAN, {8'd0, b});
                     n_push    = 2'd2;
                  end
               end
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_HALT;
         endcase
      end
   end

   always_comb begin
      wr_ptr_nx = ptr_inc(wr_ptr_ff);
      unique case (n_push)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_ptr_nx;
         default: wr_ptr_in = ptr_inc(wr_ptr_nx);
      endcase
      rd_ptr_in = rsp_fire ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(n_push) - CntW'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         pos_ff     <= '0;
         remain_ff  <= '0;
         hold_ff    <= '0;
         total_ff   <= '0;
         index_ff   <= '0;
         cid_ff     <= '0;
         samp_ff    <= '0;
         table_ff   <= '0;
         pending_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         remain_ff  <= remain_in;
         hold_ff    <= hold_in;
         total_ff   <= total_in;
         index_ff   <= index_in;
         cid_ff     <= cid_in;
         samp_ff    <= samp_in;
         table_ff   <= table_in;
         pending_ff <= pending_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ptr_ff] <= rec0;
      if (n_push == 2'd2) mem_ff[wr_ptr_nx] <= rec1;
   end

endmodule

// File: hw/rtl/jhmp_checker.sv
// Port-level checks of the marker parser and their binding to the parser module.
`include "jpeg_header_marker_parser_unit_defines.svh"

module jhmp_checker
   import jhmp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic end_kind;
   logic end_fire;

   assign end_kind = (rsp_data.out_kind == KIND_DONE) || (rsp_data.out_kind == KIND_ERROR);
   assign end_fire = rsp_valid && rsp_ready && end_kind;

   `JHMP_CHECK_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid, "record shown after reset")

   `JHMP_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stall")

   `JHMP_CHECK(a_end_is_last, rsp_valid && end_kind |-> rsp_data.last, "end record not last")

   // A done or error record is the last one that the parser ever produces.
   `JHMP_CHECK(a_halt_silent, end_fire |=> !rsp_valid, "record after done or error")

   `JHMP_CHECK(a_pair_is_scan, rsp_valid && !rsp_data.last |-> rsp_data.out_kind == KIND_SCAN, "pair")

endmodule

bind jpeg_header_marker_parser_unit jhmp_checker u_jhmp_checker (.*);

// File: tb/sv/jhmp_tb_pkg.sv
// Parser state, file constants and the record scoreboard of the marker parser testbench.
`timescale 1ns / 1ps
package jhmp_tb_pkg;
   import jhmp_pkg::*;

   typedef enum logic [4:0] {
      ST_MAGIC, ST_APP_LEN, ST_JFIF, ST_HUNT, ST_MARKER,
      ST_DQT_LEN, ST_DQT_ID, ST_DQT_DATA,
      ST_SOF_SKIP, ST_SOF_HEIGHT, ST_SOF_WIDTH, ST_SOF_COUNT, ST_SOF_COMP,
      ST_DHT_LEN, ST_DHT_ID, ST_DHT_DATA,
      ST_SOS_SKIP, ST_SOS_COUNT, ST_SOS_COMP, ST_SOS_TAIL,
      ST_SCAN, ST_HALTED
   } parser_state_type;

   localparam logic [7:0] FILE_MAGIC [4] = '{8'hFF, 8'hD8, 8'hFF, 8'hE0};
   localparam logic [7:0] JFIF_TAG [5] = '{8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};

   class jfif_record_scoreboard;
      rsp_type pending_records[$];
      int unsigned failures = 0;

      parser_state_type state = ST_MAGIC;
      logic [15:0] pos = '0;
      logic [15:0] remaining = '0;
      logic [7:0] len_hi = '0;
      logic [7:0] comp_hold = '0;
      logic [7:0] samp_hold = '0;
      logic [1:0] comp_total = '0;
      logic [1:0] comp_idx = '0;
      logic [1:0] table_id = '0;
      logic ff_seen = 1'b0;

      function rsp_type blank_record(logic [3:0] kind, logic [15:0] value);
         rsp_type rec;
         rec = '0;
         rec.out_kind = kind;
         rec.out_value = value;
         return rec;
      endfunction

      function rsp_type halt_record(logic [2:0] code);
         rsp_type rec;
         rec = blank_record(KIND_ERROR, 16'd0);
         rec.error_code = code;
         state = ST_HALTED;
         return rec;
      endfunction

      // Advances the parser by one accepted byte and queues the records it yields.
      function void parse_byte(req_type item);
         rsp_type recs[$];
         rsp_type rec;
         logic [7:0] b;
         logic [15:0] word;
         b = item.data_byte;
         word = {len_hi, b};
         if (state == ST_HALTED) return;
         if (item.at_end) begin
            case (state)
               ST_MAGIC: recs.push_back(halt_record(ERR_MAGIC));
               ST_APP_LEN, ST_JFIF: recs.push_back(halt_record(ERR_JFIF));
               ST_SCAN: recs.push_back(halt_record(ERR_EOF_SCAN));
               default: begin
                  recs.push_back(blank_record(KIND_DONE, 16'd0));
                  state = ST_HALTED;
               end
            endcase
         end else begin
            case (state)
               ST_MAGIC: begin
                  if (b != FILE_MAGIC[pos[1:0]]) recs.push_back(halt_record(ERR_MAGIC));
                  else begin
                     pos++;
                     if (pos >= 4) begin
                        pos = 0;
                        state = ST_APP_LEN;
                     end
                  end
               end
               ST_APP_LEN: begin
                  pos++;
                  if (pos >= 2) begin
                     pos = 0;
                     state = ST_JFIF;
                  end
               end
               ST_JFIF: begin
                  if (pos >= 5 || b != JFIF_TAG[pos[2:0]]) begin
                     recs.push_back(halt_record(ERR_JFIF));
                  end else begin
                     pos++;
                     if (pos >= 5) begin
                        pos = 0;
                        state = ST_HUNT;
                     end
                  end
               end
               ST_HUNT: if (b == BYTE_FF) state = ST_MARKER;
               ST_MARKER: begin
                  pos = 0;
                  // A repeated FF is fill; the marker code is still to come.
                  if (b == MRK_DQT) state = ST_DQT_LEN;
                  else if (b == MRK_SOF0) state = ST_SOF_SKIP;
                  else if (b == MRK_DHT) state = ST_DHT_LEN;
                  else if (b == MRK_SOS) state = ST_SOS_SKIP;
                  else if (b == MRK_EOI) begin
                     recs.push_back(blank_record(KIND_DONE, 16'd0));
                     state = ST_HALTED;
                  end else if (b != BYTE_FF) state = ST_HUNT;
               end
               ST_DQT_LEN, ST_DHT_LEN: begin
                  if (pos == 0) begin
                     len_hi = b;
                     pos = 1;
                  end else begin
                     remaining = (word >= 16'd3) ? word - 16'd3 : 16'd0;
                     pos = 0;
                     state = (state == ST_DQT_LEN) ? ST_DQT_ID : ST_DHT_ID;
                  end
               end
               ST_DQT_ID: begin
                  if (b > 8'd1) recs.push_back(halt_record(ERR_QUANT_ID));
                  else begin
                     table_id = b[1:0];
                     state = (remaining != 0) ? ST_DQT_DATA : ST_HUNT;
                  end
               end
               ST_DHT_ID: begin
                  table_id = {b[7:4] != 4'd0, b[3:0] != 4'd0};
                  state = (remaining != 0) ? ST_DHT_DATA : ST_HUNT;
               end
               ST_DQT_DATA, ST_DHT_DATA: begin
                  rec = blank_record(state == ST_DQT_DATA ? KIND_QUANT : KIND_HUFF, {8'h00, b});
                  rec.table_sel = table_id;
                  recs.push_back(rec);
                  remaining--;
                  if (remaining == 0) state = ST_HUNT;
               end
               ST_SOF_SKIP: begin
                  pos++;
                  if (pos >= 3) begin
                     pos = 0;
                     state = ST_SOF_HEIGHT;
                  end
               end
               ST_SOF_HEIGHT, ST_SOF_WIDTH: begin
                  if (pos == 0) begin
                     len_hi = b;
                     pos = 1;
                  end else begin
                     recs.push_back(blank_record(
                        state == ST_SOF_HEIGHT ? KIND_HEIGHT : KIND_WIDTH, word));
                     pos = 0;
                     state = (state == ST_SOF_HEIGHT) ? ST_SOF_WIDTH : ST_SOF_COUNT;
                  end
               end
               ST_SOF_COUNT, ST_SOS_COUNT: begin
                  if (b != 8'd1 && b != 8'd3) recs.push_back(halt_record(ERR_COMP_CNT));
                  else begin
                     comp_total = b[1:0];
                     comp_idx = 0;
                     pos = 0;
                     state = (state == ST_SOF_COUNT) ? ST_SOF_COMP : ST_SOS_COMP;
                  end
               end
               ST_SOF_COMP: begin
                  if (pos == 0) begin
                     comp_hold = b;
                     pos = 1;
                  end else if (pos == 1) begin
                     samp_hold = b;
                     pos = 2;
                  end else begin
                     rec = blank_record(KIND_FCOMP, 16'd0);
                     rec.comp_id = comp_hold;
                     rec.samp_x = samp_hold[7:4];
                     rec.samp_y = samp_hold[3:0];
                     rec.quant_sel = b;
                     recs.push_back(rec);
                     pos = 0;
                     comp_idx++;
                     if (comp_idx >= comp_total) state = ST_HUNT;
                  end
               end
               ST_SOS_SKIP: begin
                  pos++;
                  if (pos >= 2) begin
                     pos = 0;
                     state = ST_SOS_COUNT;
                  end
               end
               ST_SOS_COMP: begin
                  if (pos == 0) begin
                     comp_hold = b;
                     pos = 1;
                  end else begin
                     rec = blank_record(KIND_SCOMP, 16'd0);
                     rec.comp_id = comp_hold;
                     rec.dc_table = b[7:4];
                     rec.ac_table = 5'(b[3:0]) + 5'd2;
                     recs.push_back(rec);
                     pos = 0;
                     comp_idx++;
                     if (comp_idx >= comp_total) state = ST_SOS_TAIL;
                  end
               end
               ST_SOS_TAIL: begin
                  pos++;
                  if (pos >= 3) begin
                     pos = 0;
                     ff_seen = 1'b0;
                     state = ST_SCAN;
                  end
               end
               ST_SCAN: begin
                  if (!ff_seen) begin
                     if (b == BYTE_FF) ff_seen = 1'b1;
                     else recs.push_back(blank_record(KIND_SCAN, {8'h00, b}));
                  end else begin
                     // Stuffed zero restores the FF; any other byte but EOI passes both.
                     ff_seen = 1'b0;
                     if (b == BYTE_00) recs.push_back(blank_record(KIND_SCAN, 16'h00FF));
                     else if (b == MRK_EOI) begin
                        recs.push_back(blank_record(KIND_DONE, 16'd0));
                        state = ST_HALTED;
                     end else begin
                        recs.push_back(blank_record(KIND_SCAN, 16'h00FF));
                        recs.push_back(blank_record(KIND_SCAN, {8'h00, b}));
                     end
                  end
               end
               default: state = ST_HALTED;
            endcase
         end
         foreach (recs[i]) begin
            recs[i].last = (i == recs.size() - 1);
            pending_records.push_back(recs[i]);
         end
      endfunction

      function int unsigned field_differs(string name, logic [15:0] want, logic [15:0] got);
         if (want === got) return 0;
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      endfunction

      function void check_record(rsp_type got);
         rsp_type want;
         int unsigned bad;
         if (pending_records.size() == 0) begin
            $error("record with none expected: kind %0d value %0d", got.out_kind, got.out_value);
            failures++;
            return;
         end
         want = pending_records.pop_front();
         bad = field_differs("out_kind", want.out_kind, got.out_kind);
         bad += field_differs("out_value", want.out_value, got.out_value);
         bad += field_differs("table_sel", want.table_sel, got.table_sel);
         bad += field_differs("comp_id", want.comp_id, got.comp_id);
         bad += field_differs("samp_x", want.samp_x, got.samp_x);
         bad += field_differs("samp_y", want.samp_y, got.samp_y);
         bad += field_differs("quant_sel", want.quant_sel, got.quant_sel);
         bad += field_differs("dc_table", want.dc_table, got.dc_table);
         bad += field_differs("ac_table", want.ac_table, got.ac_table);
         bad += field_differs("error_code", want.error_code, got.error_code);
         bad += field_differs("last", want.last, got.last);
         if (bad != 0) failures++;
      endfunction
   endclass

endpackage

// File: tb/sv/testbench.sv
// Top level that feeds one JFIF stream through the marker parser and checks every record.
`timescale 1ns / 1ps
module testbench;
   import jhmp_pkg::*;
   import jhmp_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   jfif_record_scoreboard records = new();
   req_type file_stream[$];
   int drain_index = -1;
   int hold_index = -1;
   int idle_phase = 0;
   bit hold_request = 1'b0;
   int unsigned cycle_count = 0;

   jpeg_header_marker_parser_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void put(input logic [7:0] b);
      req_type it;
      it.data_byte = b;
      it.at_end = 1'b0;
      file_stream.push_back(it);
   endfunction

   function automatic void put_random(input int count);
      for (int i = 0; i < count; i++) put(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_table(input logic [7:0] marker, input logic [15:0] len,
                                     input logic [7:0] id);
      put(BYTE_FF);
      put(marker);
      put(len[15:8]);
      put(len[7:0]);
      put(id);
      if (len > 16'd3) put_random(len - 3);
   endfunction

   function automatic void put_frame(input logic [15:0] height, input logic [15:0] width,
                                     input logic [7:0] count);
      put(BYTE_FF);
      put(MRK_SOF0);
      put_random(3);
      put(height[15:8]);
      put(height[7:0]);
      put(width[15:8]);
      put(width[7:0]);
      put(count);
      put_random(3 * count);
   endfunction

   // A marker the parser skips, sometimes preceded by fill bytes.
   function automatic void put_other_marker();
      logic [7:0] code;
      put(BYTE_FF);
      repeat ($urandom_range(0, 2)) put(BYTE_FF);
      do code = 8'($urandom_range(0, 254));
      while (code inside {MRK_DQT, MRK_SOF0, MRK_DHT, MRK_SOS, MRK_EOI});
      put(code);
   endfunction

   // Only one reset is allowed, so the whole run is a single file: header
   // segments first, then one scan, then the end of the file.
   function automatic void build_file();
      req_type it;
      int pick;
      int scan_start;
      logic [7:0] code;
      for (int i = 0; i < 4; i++) put(FILE_MAGIC[i]);
      put(8'h00);
      put(8'h10);
      for (int i = 0; i < 5; i++) put(JFIF_TAG[i]);
      put(BYTE_FF);
      put(BYTE_FF);
      put_table(MRK_DQT, 16'd2, 8'd1);
      put_table(MRK_DHT, 16'd4, 8'h11);
      put_frame(16'hFFFF, 16'h0000, 8'd3);
      put_table(MRK_DQT, 16'h0103, 8'd0);
      while (file_stream.size() < 720) begin
         case ($urandom_range(0, 5))
            0: put_table(MRK_DQT, 16'($urandom_range(0, 20)), 8'($urandom_range(0, 1)));
            1: put_table(MRK_DHT, 16'($urandom_range(0, 20)), 8'($urandom_range(0, 255)));
            2: put_frame(16'($urandom), 16'($urandom), $urandom_range(0, 1) ? 8'd3 : 8'd1);
            3: repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 254)));
            default: put_other_marker();
         endcase
      end
      drain_index = file_stream.size();
      put(BYTE_FF);
      put(MRK_SOS);
      put_random(2);
      put(8'd3);
      put(8'h01);
      put(8'h00);
      put(8'h02);
      put(8'hFF);
      put_random(2);
      put_random(3);
      scan_start = file_stream.size();
      hold_index = scan_start + 40;
      while (file_stream.size() < scan_start + 520) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) put(8'($urandom_range(0, 254)));
         else if (pick < 82) begin
            put(BYTE_FF);
            put(BYTE_00);
         end else if (pick < 88) begin
            put(BYTE_FF);
            put(BYTE_FF);
         end else begin
            put(BYTE_FF);
            do code = 8'($urandom_range(0, 255));
            while (code == MRK_EOI);
            put(code);
         end
      end
      if ($urandom_range(0, 1)) begin
         put(BYTE_FF);
         put(MRK_EOI);
      end else begin
         it.data_byte = 8'($urandom_range(0, 255));
         it.at_end = 1'b1;
         file_stream.push_back(it);
      end
      // The parser has halted; these bytes must produce nothing.
      repeat (30) begin
         it.data_byte = 8'($urandom_range(0, 255));
         it.at_end = 1'($urandom_range(0, 1));
         file_stream.push_back(it);
      end
   endfunction

   task automatic send_byte(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock);
      while (req_ready !== 1'b1);
      records.parse_byte(item);
   endtask

   initial begin
      int sender_pct;
      build_file();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int idx = 0; idx < file_stream.size(); idx++) begin
         idle_phase = idx * 3 / file_stream.size();
         sender_pct = (idle_phase == 0) ? 9 : (idle_phase == 1) ? 64 : 0;
         if (idx == hold_index) hold_request = 1'b1;
         send_byte(file_stream[idx]);
         if (idx + 1 < file_stream.size()) begin
            if (idx + 1 == drain_index) begin
               req_valid <= 1'b0;
               do @(posedge clock);
               while (records.pending_records.size() != 0);
            end else if ($urandom_range(0, 99) < sender_pct) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      while (records.pending_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (records.failures == 0 && records.pending_records.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Result side: checks each transfer and picks the ready level for the next cycle.
   initial begin
      int unsigned hold_left;
      int unsigned receiver_pct;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) records.check_record(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         receiver_pct = (idle_phase == 0) ? 64 : (idle_phase == 1) ? 9 : 0;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
